// ===== src/mwbfr_pkg.sv =====
package mwbfr_pkg;

    localparam int MAX_WIRES   = 6;
    localparam int WIRE_W      = 6;
    localparam int CRC_W       = 11;
    localparam int ACC_W       = 16;
    localparam int CNT_W       = 3;
    localparam int CFG_W       = 3;
    localparam int VALUE_W     = 14;
    localparam int WIDTH_W     = 4;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 2;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;

    localparam logic [CRC_W-1:0] CRC_POLY      = 11'h583;
    localparam logic [CFG_W-1:0] WIRES_DEFAULT = 3'd3;

    typedef enum logic [2:0] {
        PH_ACQUIRE = 3'b001,
        PH_READ    = 3'b010,
        PH_CRC     = 3'b100
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        EV_FULL     = 2'd0,
        EV_RESIDUAL = 2'd1,
        EV_DONE     = 2'd2,
        EV_ERROR    = 2'd3
    } event_kind_t;

    typedef enum logic [CODE_W-1:0] {
        ERR_NO_CHANGE = 2'd0,
        ERR_BAD_PRIO  = 2'd1,
        ERR_RANGE     = 2'd2
    } error_code_t;

    typedef struct packed {
        logic               valid;
        logic [WIRE_W-1:0]  wires;
    } item_t;

    typedef struct packed {
        logic                valid;
        event_kind_t         kind;
        logic [VALUE_W-1:0]  value;
        logic [WIDTH_W-1:0]  width;
        logic                crc_ok;
        error_code_t         code;
        logic [WIRE_W-1:0]   prio;
    } result_t;

    function automatic logic [WIRE_W-1:0] wire_mask(input logic [CFG_W-1:0] w);
        logic [WIRE_W-1:0] m;
        m = '0;
        for (int i = 0; i < WIRE_W; i++)
        begin
            if (i < int'(w))
                m[i] = 1'b1;
        end
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] chunk_len(input logic [CFG_W-1:0] w);
        case (w)
            3'd2:    return 3'd7;
            3'd3:    return 3'd5;
            3'd4:    return 3'd3;
            3'd5:    return 3'd3;
            3'd6:    return 3'd2;
            default: return 3'd7;
        endcase
    endfunction

    function automatic logic [WIDTH_W-1:0] chunk_bits(input logic [CFG_W-1:0] w);
        case (w)
            3'd3, 3'd5: return 4'd14;
            default:    return 4'd11;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] end_flips(input logic [CFG_W-1:0] w);
        case (w)
            3'd2:    return 3'd3;
            3'd3:    return 3'd2;
            default: return 3'd1;
        endcase
    endfunction

    // (2^w - 1)^end_flips - 1
    function automatic logic [ACC_W-1:0] end_value(input logic [CFG_W-1:0] w);
        case (w)
            3'd2:    return 16'd26;
            3'd3:    return 16'd48;
            3'd4:    return 16'd14;
            3'd5:    return 16'd30;
            3'd6:    return 16'd62;
            default: return 16'd26;
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] chunk_max(input logic [CFG_W-1:0] w);
        case (w)
            3'd3, 3'd5: return 16'd16384;
            default:    return 16'd2048;
        endcase
    endfunction

    // chunk_max + 2^(bits - 8)
    function automatic logic [ACC_W-1:0] chunk_limit(input logic [CFG_W-1:0] w);
        case (w)
            3'd3, 3'd5: return 16'd16448;
            default:    return 16'd2056;
        endcase
    endfunction

    function automatic logic [CRC_W-1:0] crc_entry(input logic [WIRE_W-1:0] idx,
                                                   input logic [CFG_W-1:0] w);
        logic [CRC_W-1:0] c;
        c = CRC_W'(idx);
        for (int i = 0; i < MAX_WIRES; i++)
        begin
            if (i < int'(w))
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== src/multiwire_bus_frame_receiver.sv =====
// channel   | signals                        | contents (low bit up)
// ----------+--------------------------------+------------------------------------------
// s_axis    | tvalid tready tdata[7:0]       | wire_bits[5:0], zero pad
// m_axis    | tvalid tready tdata[31:0] tuser| tdata: chunk_value[13:0] chunk_width[17:14]
//           |                                |   crc_ok[18] error_code[20:19]
//           |                                |   frame_priority[26:21]; tuser: event_kind
// cfg       | cfg_we cfg_wdata[2:0]          | wire_count
//
// One request per clock unless m_axis stalls; its result is registered in the output register.
// The wire-state register feeds one decode step (multiply-add, CRC table step, compares).
// Stalls on m_axis hold the output register and then the input register; tready drops
// only when both are full.
// Reset gives wire_count 3, acquire phase, all frame state cleared.
module multiwire_bus_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mwbfr_pkg::CFG_W-1:0]     cfg_wdata,     // wire_count
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mwbfr_pkg::S_TDATA_W-1:0] s_axis_tdata,  // wire_bits
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // chunk_value, chunk_width, crc_ok, error_code, frame_priority
    output logic [mwbfr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [mwbfr_pkg::M_TUSER_W-1:0] m_axis_tuser   // event_kind
);
    import mwbfr_pkg::*;

    item_t   item;
    result_t result;
    logic    advance;

    mwbfr_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .advance       (advance),
        .item          (item)
    );

    mwbfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .advance   (advance),
        .result    (result)
    );

    mwbfr_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .result        (result),
        .advance       (advance),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== src/mwbfr_in_reg.sv =====
module mwbfr_in_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [mwbfr_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                         advance,
    output mwbfr_pkg::item_t             item
);
    import mwbfr_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [WIRE_W-1:0] wires_reg;
    logic              take;

    assign s_axis_tready = !valid_reg || advance;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign valid_next    = take ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            wires_reg <= s_axis_tdata[WIRE_W-1:0];
    end

    assign item.valid = valid_reg;
    assign item.wires = wires_reg;

endmodule

// ===== src/mwbfr_core.sv =====
module mwbfr_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mwbfr_pkg::CFG_W-1:0]   cfg_wdata,
    input  mwbfr_pkg::item_t              item,
    input  logic                          advance,
    output mwbfr_pkg::result_t            result
);
    import mwbfr_pkg::*;

    logic [CFG_W-1:0]  wires_cfg_reg;
    logic [CFG_W-1:0]  wires_cfg_next;
    phase_t            phase_reg, phase_next;
    logic [WIRE_W-1:0] prev_reg, prev_next;
    logic [WIRE_W-1:0] prio_reg, prio_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              fire;
    logic [WIRE_W-1:0] mask;
    logic [WIRE_W-1:0] bits;
    logic [WIRE_W-1:0] digit;
    logic [WIRE_W-1:0] crc_idx;
    logic [CRC_W-1:0]  crc_step;
    logic [21:0]       acc_prod;
    logic [ACC_W-1:0]  acc_new;
    logic [CNT_W-1:0]  cnt_new;
    logic [CNT_W-1:0]  len;
    logic [CNT_W-1:0]  len_crc;
    logic [WIDTH_W-1:0] nbits;

    assign fire    = item.valid && advance;
    assign mask    = wire_mask(wires_cfg_reg);
    assign bits    = item.wires & mask;
    assign digit   = bits ^ prev_reg;
    assign crc_idx = (bits ^ crc_reg[WIRE_W-1:0] ^ prio_reg) & mask;
    assign crc_step = (crc_reg >> wires_cfg_reg) ^ crc_entry(crc_idx, wires_cfg_reg);
    assign acc_prod = 22'(acc_reg) * 22'(mask);
    assign acc_new  = acc_prod[ACC_W-1:0] + ACC_W'(digit) - 16'd1;
    assign cnt_new  = cnt_reg + 3'd1;
    assign len      = chunk_len(wires_cfg_reg);
    assign len_crc  = (wires_cfg_reg == 3'd3) ? len - 3'd1 : len;
    assign nbits    = chunk_bits(wires_cfg_reg);

    // clamp the written wire count into 2..MAX_WIRES
    always_comb
    begin
        if (cfg_wdata < 3'd2)
            wires_cfg_next = 3'd2;
        else if (cfg_wdata > CFG_W'(MAX_WIRES))
            wires_cfg_next = CFG_W'(MAX_WIRES);
        else
            wires_cfg_next = cfg_wdata;
    end

    always_comb
    begin
        phase_next = phase_reg;
        prev_next  = prev_reg;
        prio_next  = prio_reg;
        crc_next   = crc_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        result     = '0;

        if (fire)
        begin
            prev_next = bits;
            case (phase_reg)
                PH_READ, PH_CRC:
                begin
                    if (phase_reg == PH_READ)
                        crc_next = crc_step;
                    if (digit == '0)
                    begin
                        result.valid = 1'b1;
                        result.kind  = EV_ERROR;
                        result.code  = ERR_NO_CHANGE;
                        result.prio  = prio_reg;
                        phase_next   = PH_ACQUIRE;
                        acc_next     = '0;
                        cnt_next     = '0;
                    end
                    else
                    begin
                        acc_next = acc_new;
                        cnt_next = cnt_new;
                        if (phase_reg == PH_CRC)
                        begin
                            if (cnt_new == len_crc)
                            begin
                                result.valid  = 1'b1;
                                result.kind   = EV_DONE;
                                result.crc_ok = (acc_new == ACC_W'(crc_reg));
                                result.prio   = prio_reg;
                                phase_next    = PH_ACQUIRE;
                                acc_next      = '0;
                                cnt_next      = '0;
                            end
                        end
                        else if (cnt_new == end_flips(wires_cfg_reg)
                                 && acc_new == end_value(wires_cfg_reg))
                        begin
                            phase_next = PH_CRC;
                            acc_next   = '0;
                            cnt_next   = '0;
                        end
                        else if (cnt_new == len)
                        begin
                            acc_next     = '0;
                            cnt_next     = '0;
                            result.valid = 1'b1;
                            result.prio  = prio_reg;
                            if (acc_new >= chunk_limit(wires_cfg_reg))
                            begin
                                result.kind = EV_ERROR;
                                result.code = ERR_RANGE;
                                phase_next  = PH_ACQUIRE;
                            end
                            else if (acc_new >= chunk_max(wires_cfg_reg))
                            begin
                                result.kind  = EV_RESIDUAL;
                                result.value = VALUE_W'(acc_new - chunk_max(wires_cfg_reg));
                                result.width = nbits - 4'd8;
                                phase_next   = PH_CRC;
                            end
                            else
                            begin
                                result.kind  = EV_FULL;
                                result.value = acc_new[VALUE_W-1:0];
                                result.width = nbits;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_ACQUIRE;
                    if (bits != '0)
                    begin
                        if ((bits & (bits - 6'd1)) != '0)
                        begin
                            result.valid = 1'b1;
                            result.kind  = EV_ERROR;
                            result.code  = ERR_BAD_PRIO;
                        end
                        else
                        begin
                            prio_next  = bits;
                            crc_next   = '0;
                            acc_next   = '0;
                            cnt_next   = '0;
                            phase_next = PH_READ;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wires_cfg_reg <= WIRES_DEFAULT;
            phase_reg     <= PH_ACQUIRE;
            prev_reg      <= '0;
            prio_reg      <= '0;
            crc_reg       <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end
        else if (cfg_we)
        begin
            // a new wire count drops any frame in progress
            wires_cfg_reg <= wires_cfg_next;
            phase_reg     <= PH_ACQUIRE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            prev_reg  <= prev_next;
            prio_reg  <= prio_next;
            crc_reg   <= crc_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < chunk_len(wires_cfg_reg))
        else $error("digit count reached chunk length");

    a_crc_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(crc_reg))
        else $error("crc changed without an accepted request");

    a_read_prio_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_READ || phase_reg == PH_CRC) |-> $onehot(prio_reg))
        else $error("frame in progress without a one-hot priority");

endmodule

// ===== src/mwbfr_out_reg.sv =====
module mwbfr_out_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mwbfr_pkg::result_t              result,
    output logic                            advance,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mwbfr_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [mwbfr_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    import mwbfr_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign advance    = !valid_reg || m_axis_tready;
    assign valid_next = result.valid ? 1'b1 : (m_axis_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
            res_reg <= result;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tdata  = {5'd0, res_reg.prio, res_reg.code, res_reg.crc_ok,
                            res_reg.width, res_reg.value};

endmodule

// ===== sim/tb_multiwire_bus_frame_receiver.sv =====
`timescale 1ns / 1ps

module tb_multiwire_bus_frame_receiver;

    import mwbfr_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int ITEMS_PER_STEP = 250;

    typedef struct {
        event_kind_t         kind;
        logic [VALUE_W-1:0]  value;
        logic [WIDTH_W-1:0]  width;
        logic                crc_ok;
        error_code_t         code;
        logic [WIRE_W-1:0]   prio;
    } frame_event_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [CFG_W-1:0]       cfg_wdata     = WIRES_DEFAULT;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;  // wire_bits[5:0], zero pad
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    // chunk_value[13:0] chunk_width[17:14] crc_ok[18] error_code[20:19]
    // frame_priority[26:21], zero pad
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic [M_TUSER_W-1:0]   m_axis_tuser;        // event_kind[1:0]

    // decoder state mirrored on the testbench side
    logic [CFG_W-1:0]       wire_count    = WIRES_DEFAULT;
    phase_t                 rx_phase      = PH_ACQUIRE;
    logic [WIRE_W-1:0]      prev_wires    = '0;
    logic [WIRE_W-1:0]      frame_prio    = '0;
    logic [CRC_W-1:0]       running_crc   = '0;
    logic [ACC_W-1:0]       digit_acc     = '0;
    logic [CNT_W-1:0]       digit_count   = '0;

    frame_event_t           expected_events[$];

    bit                     idle_enable   = 1'b1;
    int                     stall_left    = 0;
    int                     fail_count    = 0;
    int                     decoded_items = 0;
    int                     settings_used = 0;
    int                     n_full        = 0;
    int                     n_residual    = 0;
    int                     n_done        = 0;
    int                     n_crc_ok      = 0;
    int                     n_error       = 0;

    multiwire_bus_frame_receiver u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int eff_wires(input logic [CFG_W-1:0] wc);
        if (wc < 2)
            return 2;
        if (wc > MAX_WIRES)
            return MAX_WIRES;
        return int'(wc);
    endfunction

    function automatic int chunk_digits(input int w);
        case (w)
            2:       return 7;
            3:       return 5;
            4, 5:    return 3;
            default: return 2;
        endcase
    endfunction

    function automatic int chunk_bit_count(input int w);
        return (w == 3 || w == 5) ? 14 : 11;
    endfunction

    function automatic int end_digits(input int w);
        case (w)
            2:       return 3;
            3:       return 2;
            default: return 1;
        endcase
    endfunction

    function automatic int cur_wires();
        return eff_wires(wire_count);
    endfunction

    function automatic int unsigned digit_base();
        return (1 << cur_wires()) - 1;
    endfunction

    function automatic logic [WIRE_W-1:0] lane_mask();
        return WIRE_W'(digit_base());
    endfunction

    function automatic int unsigned full_limit();
        return 1 << chunk_bit_count(cur_wires());
    endfunction

    function automatic int unsigned range_limit();
        return full_limit() + (1 << (chunk_bit_count(cur_wires()) - 8));
    endfunction

    function automatic int crc_digits();
        return (cur_wires() == 3) ? chunk_digits(3) - 1 : chunk_digits(cur_wires());
    endfunction

    function automatic int unsigned base_power(input int n);
        int unsigned p;
        p = 1;
        for (int i = 0; i < n; i++)
            p = p * digit_base();
        return p;
    endfunction

    // random levels on the wires above the active count; the decoder masks them
    function automatic logic [WIRE_W-1:0] upper_noise();
        return WIRE_W'($urandom) & ~lane_mask();
    endfunction

    function automatic logic [CRC_W-1:0] crc_fold(input logic [WIRE_W-1:0] idx, input int w);
        logic [CRC_W-1:0] c;
        c = CRC_W'(idx);
        for (int i = 0; i < w; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic frame_event_t make_event(input event_kind_t kind,
                                                input int unsigned value,
                                                input int unsigned width,
                                                input logic ok,
                                                input error_code_t code,
                                                input logic [WIRE_W-1:0] prio);
        frame_event_t ev;
        ev.kind   = kind;
        ev.value  = VALUE_W'(value);
        ev.width  = WIDTH_W'(width);
        ev.crc_ok = ok;
        ev.code   = code;
        ev.prio   = prio;
        return ev;
    endfunction

    function automatic void return_to_acquire();
        rx_phase    = PH_ACQUIRE;
        digit_acc   = '0;
        digit_count = '0;
    endfunction

    // advance the mirrored decoder by one accepted wire state
    function automatic void decode_wire_state(input logic [WIRE_W-1:0] raw);
        int w;
        int unsigned maxv, val_max, val_end, acc;
        logic [WIRE_W-1:0] bits, last, digit, idx;
        w       = cur_wires();
        maxv    = digit_base();
        val_max = full_limit();
        val_end = base_power(end_digits(w)) - 1;
        bits    = raw & lane_mask();
        last    = prev_wires;
        prev_wires = bits;

        if (rx_phase != PH_READ && rx_phase != PH_CRC)
        begin
            rx_phase = PH_ACQUIRE;
            if (bits == '0)
                return;
            decoded_items++;
            if ((bits & (bits - 1'b1)) != '0)
            begin
                expected_events.push_back(make_event(EV_ERROR, 0, 0, 1'b0, ERR_BAD_PRIO, '0));
                return;
            end
            frame_prio  = bits;
            running_crc = '0;
            digit_acc   = '0;
            digit_count = '0;
            rx_phase    = PH_READ;
            return;
        end
        decoded_items++;

        // CRC digits themselves do not enter the running CRC
        if (rx_phase == PH_READ)
        begin
            idx = (bits ^ WIRE_W'(running_crc) ^ frame_prio) & lane_mask();
            running_crc = (running_crc >> w) ^ crc_fold(idx, w);
        end

        digit = bits ^ last;
        if (digit == '0)
        begin
            expected_events.push_back(make_event(EV_ERROR, 0, 0, 1'b0, ERR_NO_CHANGE,
                                                 frame_prio));
            return_to_acquire();
            return;
        end

        acc = (int'(digit_acc) * maxv + int'(digit) - 1) & 32'hFFFF;
        digit_acc   = ACC_W'(acc);
        digit_count = digit_count + 1'b1;

        if (rx_phase == PH_CRC)
        begin
            if (digit_count == crc_digits())
            begin
                expected_events.push_back(make_event(EV_DONE, 0, 0,
                                                     acc == int'(running_crc), ERR_NO_CHANGE,
                                                     frame_prio));
                return_to_acquire();
            end
            return;
        end

        if (digit_count == end_digits(w) && acc == val_end)
        begin
            rx_phase    = PH_CRC;
            digit_acc   = '0;
            digit_count = '0;
            return;
        end
        if (digit_count == chunk_digits(w))
        begin
            if (acc >= range_limit())
            begin
                expected_events.push_back(make_event(EV_ERROR, 0, 0, 1'b0, ERR_RANGE,
                                                     frame_prio));
                return_to_acquire();
                return;
            end
            digit_acc   = '0;
            digit_count = '0;
            if (acc >= val_max)
            begin
                expected_events.push_back(make_event(EV_RESIDUAL, acc - val_max,
                                                     chunk_bit_count(w) - 8, 1'b0,
                                                     ERR_NO_CHANGE, frame_prio));
                rx_phase = PH_CRC;
                return;
            end
            expected_events.push_back(make_event(EV_FULL, acc, chunk_bit_count(w), 1'b0,
                                                 ERR_NO_CHANGE, frame_prio));
        end
    endfunction

    task automatic send_wires(input logic [WIRE_W-1:0] wires);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'(wires);
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_wire_state(wires);
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    task automatic send_digit(input int unsigned dv);
        send_wires(((prev_wires ^ WIRE_W'(dv + 1)) & lane_mask()) | upper_noise());
    endtask

    task automatic send_acquire();
        send_wires(WIRE_W'(1 << $urandom_range(0, cur_wires() - 1)) | upper_noise());
    endtask

    // send a value as ndig base-(2^W-1) digits, most significant first;
    // stop early once the decoder leaves the phase it started in
    task automatic send_value(input int unsigned value, input int ndig);
        int unsigned weight;
        phase_t start_phase;
        start_phase = rx_phase;
        weight = base_power(ndig - 1);
        for (int i = 0; i < ndig && rx_phase == start_phase; i++)
        begin
            send_digit((value / weight) % digit_base());
            weight = weight / digit_base();
        end
    endtask

    task automatic write_wire_count(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        wire_count = value;
        return_to_acquire();
        settings_used++;
    endtask

    task automatic send_random_frame();
        int r;
        int unsigned v;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 3)) send_wires(WIRE_W'($urandom));
            return;
        end
        if (r < 12)
            send_wires(upper_noise());
        send_acquire();
        repeat ($urandom_range(0, 3))
        begin
            if (rx_phase == PH_READ)
            begin
                case ($urandom_range(0, 9))
                    0:       v = 0;
                    1:       v = full_limit() - 1;
                    default: v = $urandom_range(0, full_limit() - 1);
                endcase
                send_value(v, chunk_digits(cur_wires()));
            end
        end
        if (rx_phase == PH_READ)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_value($urandom_range(full_limit(), range_limit() - 1),
                           chunk_digits(cur_wires()));
            else if (r < 80)
                send_value(base_power(end_digits(cur_wires())) - 1, end_digits(cur_wires()));
            else if (r < 90)
                send_value($urandom_range(range_limit(),
                                          base_power(chunk_digits(cur_wires())) - 1),
                           chunk_digits(cur_wires()));
            else
                send_wires(prev_wires | upper_noise());
        end
        if (rx_phase == PH_CRC)
        begin
            if ($urandom_range(0, 3) == 0)
                v = $urandom_range(0, base_power(crc_digits()) - 1);
            else
                v = running_crc;
            send_value(v, crc_digits());
        end
    endtask

    task automatic test_acquire_cases();
        send_wires(6'h00);          // idle bus, ignored
        send_wires(6'h3F);          // several wires low: bad priority
        send_wires(6'h39);          // one active wire low, upper wires noisy
        send_wires(6'h01);          // no change
    endtask

    task automatic test_chunk_limits();
        send_wires(6'h04);
        send_value(full_limit() - 1, chunk_digits(cur_wires()));
        send_value(range_limit(), chunk_digits(cur_wires()));
    endtask

    task automatic test_residual_and_crc();
        send_wires(6'h02);
        send_value(range_limit() - 1, chunk_digits(cur_wires()));
        send_value(running_crc, crc_digits());
    endtask

    task automatic test_random_frames(input int n_items);
        int target;
        target = decoded_items + n_items;
        while (decoded_items < target)
            send_random_frame();
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        frame_event_t want;
        logic [M_TDATA_W-1:0] word;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                word = m_axis_tdata;
                if (expected_events.size() == 0)
                begin
                    $error("result with nothing expected: tuser %0d tdata %h",
                           m_axis_tuser, word);
                    fail_count++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", want.kind, m_axis_tuser);
                    check_field("chunk_value", want.value, word[13:0]);
                    check_field("chunk_width", want.width, word[17:14]);
                    check_field("crc_ok", want.crc_ok, word[18]);
                    check_field("error_code", want.code, word[20:19]);
                    check_field("frame_priority", want.prio, word[26:21]);
                    case (want.kind)
                        EV_FULL:     n_full++;
                        EV_RESIDUAL: n_residual++;
                        EV_DONE:
                        begin
                            n_done++;
                            if (want.crc_ok)
                                n_crc_ok++;
                        end
                        default:     n_error++;
                    endcase
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    m_axis_tready <= 1'b1;
            end
            else if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = $urandom_range(1, 19);
            end
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_acquire_cases();
        test_chunk_limits();
        test_residual_and_crc();

        write_wire_count(3'd2);
        test_random_frames(ITEMS_PER_STEP);
        write_wire_count(3'd6);
        test_random_frames(ITEMS_PER_STEP);
        write_wire_count(3'd0);
        test_random_frames(ITEMS_PER_STEP);
        write_wire_count(3'd7);
        test_random_frames(ITEMS_PER_STEP);
        write_wire_count(3'd5);
        test_random_frames(ITEMS_PER_STEP);
        write_wire_count(3'd4);
        test_random_frames(ITEMS_PER_STEP);
        write_wire_count(3'd1);
        test_random_frames(ITEMS_PER_STEP);

        // full rate on both sides for the last stretch
        idle_enable = 1'b0;
        write_wire_count(3'd3);
        test_random_frames(ITEMS_PER_STEP);

        s_axis_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d wire states across %0d wire-count settings.",
                 decoded_items, settings_used);
        $display("Checked %0d full, %0d residual, %0d frame ends (%0d crc good), %0d errors.",
                 n_full, n_residual, n_done, n_crc_ok, n_error);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
